// ----- rtl/nbody_gravity_accumulate_integrate_core_defines.svh -----
// Assertion macros shared by the gravity accumulate and integrate core.
// Used by modules that check their own control sequencing; no other content.
`ifndef NBODY_GRAVITY_ACCUMULATE_INTEGRATE_CORE_DEFINES_SVH
`define NBODY_GRAVITY_ACCUMULATE_INTEGRATE_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define NBGAI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define NBGAI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nbgai_pkg.sv -----
// Shared types and constants for the gravity accumulate and integrate core.
// No dependencies; every RTL module refers to it by scoped names.
package nbgai_pkg;

  // Depth of the queue between the front pipeline and the back sequencer
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgGravity   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSoftening = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeStep  = 2'd2;
  localparam logic [31:0] GravityReset   = 32'd65536;
  localparam logic [31:0] SofteningReset = 32'd655;
  localparam logic [31:0] TimeStepReset  = 32'd655;

  // Widths of the softened squared distance, scaled mass and acceleration sum
  localparam int unsigned RW   = 50;
  localparam int unsigned QW   = 48;
  localparam int unsigned AccW = 48;

  // Shared chunked multiplier: 32-bit chunks of A times a 33-bit B
  localparam int unsigned MulChunks = 3;
  localparam int unsigned MulAW     = MulChunks * 32;
  localparam int unsigned MulBW     = 33;
  localparam int unsigned MulPW     = MulAW + MulBW;

  // One request as it arrives on the ports
  typedef struct packed {
    logic [2:0][31:0] tgt_pos;
    logic [2:0][31:0] tgt_vel;
    logic [2:0][31:0] src_pos;
    logic [31:0]      src_mass;
    logic             first_source;
    logic             last_source;
  } in_item_t;

  // One classified pair handed from front to back
  typedef struct packed {
    logic [2:0][31:0] tgt_pos;
    logic [2:0][31:0] tgt_vel;
    logic [2:0][31:0] abs_d;
    logic [2:0]       neg_d;
    logic [RW-1:0]    r_sq;
    logic [QW-1:0]    q_pull;
    logic             first_source;
    logic             last_source;
  } pair_t;

  // One integrated target state
  typedef struct packed {
    logic [2:0][31:0] new_pos;
    logic [2:0][31:0] new_vel;
  } result_t;

endpackage

// ----- rtl/nbgai_front.sv -----
// Front pipeline: displacement, squared distance and scaled source mass.
// Depends on nbgai_pkg; feeds nbgai_queue.
module nbgai_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         gravity_const,
  input  logic [31:0]         softening_sq,
  input  logic                push,
  output logic                full,
  input  nbgai_pkg::in_item_t in_item,
  input  logic                q_full,
  output logic                q_push,
  output nbgai_pkg::pair_t    q_data
);

  logic [32:0] d_wide [3];
  logic [31:0] d_abs  [3];

  logic             s1_valid;
  logic [2:0][31:0] s1_tp;
  logic [2:0][31:0] s1_tv;
  logic [2:0][31:0] s1_absd;
  logic [2:0]       s1_neg;
  logic [31:0]      s1_mass;
  logic             s1_first;
  logic             s1_last;

  logic             s2_valid;
  logic [2:0][31:0] s2_tp;
  logic [2:0][31:0] s2_tv;
  logic [2:0][31:0] s2_absd;
  logic [2:0]       s2_neg;
  logic [63:0]      s2_sq [3];
  logic [63:0]      s2_gm;
  logic             s2_first;
  logic             s2_last;

  logic s1_take;
  logic s2_ready;
  logic s1_ready;

  // Stall a stage only when the one after it is blocked
  assign s2_ready = !s2_valid || !q_full;
  assign s1_ready = !s1_valid || s2_ready;
  assign full     = !s1_ready;
  assign s1_take  = push && s1_ready;
  assign q_push   = s2_valid && !q_full;

  // Form the exact 33-bit displacement and its magnitude per axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_wide[k] = {in_item.src_pos[k][31], in_item.src_pos[k]}
                - {in_item.tgt_pos[k][31], in_item.tgt_pos[k]};
      d_abs[k]  = d_wide[k][32] ? 32'(~d_wide[k] + 33'd1) : d_wide[k][31:0];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= s1_take || (s1_valid && !s2_ready);
      s2_valid <= (s1_valid && s2_ready) || (s2_valid && q_full);
    end
  end

  // Stage one: capture the request and its displacement
  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_tp    <= in_item.tgt_pos;
      s1_tv    <= in_item.tgt_vel;
      s1_mass  <= in_item.src_mass;
      s1_first <= in_item.first_source;
      s1_last  <= in_item.last_source;
      for (int k = 0; k < 3; k++) begin
        s1_absd[k] <= d_abs[k];
        s1_neg[k]  <= d_wide[k][32];
      end
    end
  end

  // Stage two: square each displacement and scale the mass by gravity
  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_tp    <= s1_tp;
      s2_tv    <= s1_tv;
      s2_absd  <= s1_absd;
      s2_neg   <= s1_neg;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_gm    <= 64'(gravity_const) * 64'(s1_mass);
      for (int k = 0; k < 3; k++) begin
        s2_sq[k] <= 64'(s1_absd[k]) * 64'(s1_absd[k]);
      end
    end
  end

  // Sum the truncated squares with the softening term
  always_comb begin
    q_data.tgt_pos      = s2_tp;
    q_data.tgt_vel      = s2_tv;
    q_data.abs_d        = s2_absd;
    q_data.neg_d        = s2_neg;
    q_data.first_source = s2_first;
    q_data.last_source  = s2_last;
    q_data.q_pull       = s2_gm[63:16];
    q_data.r_sq         = nbgai_pkg::RW'(softening_sq)
                        + nbgai_pkg::RW'(s2_sq[0][63:16])
                        + nbgai_pkg::RW'(s2_sq[1][63:16])
                        + nbgai_pkg::RW'(s2_sq[2][63:16]);
  end

endmodule

// ----- rtl/nbgai_queue.sv -----
// Short queue of classified pairs between the front and back parts.
// Depends on nbgai_pkg for the pair type.
module nbgai_queue #(
  parameter int unsigned Depth = nbgai_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  nbgai_pkg::pair_t wdata,
  input  logic             pop,
  output logic             empty,
  output nbgai_pkg::pair_t rdata
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  nbgai_pkg::pair_t mem [Depth];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // Store the incoming pair
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/nbgai_mul.sv -----
// Shared multi-cycle multiplier: one 32-bit chunk of A times B per cycle.
// Depends on nbgai_pkg for operand widths; used by nbgai_back.
module nbgai_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nbgai_pkg::MulAW-1:0] a,
  input  logic [nbgai_pkg::MulBW-1:0] b,
  output logic                        busy,
  output logic                        done,
  output logic [nbgai_pkg::MulPW-1:0] p
);

  localparam int unsigned ProdW = 32 + nbgai_pkg::MulBW;
  localparam int unsigned IdxW  = $clog2(nbgai_pkg::MulChunks + 1);

  logic [nbgai_pkg::MulChunks-1:0][31:0] a_r;
  logic [nbgai_pkg::MulBW-1:0]           b_r;
  logic [IdxW-1:0]                       icnt;
  logic [ProdW-1:0]                      prod;
  logic                                  prod_v;
  logic [IdxW-1:0]                       prod_idx;
  logic [nbgai_pkg::MulPW-1:0]           acc;

  assign p = acc;

  // Issue one partial product per cycle, then add it in at its offset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      prod_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc    <= '0;
        icnt   <= '0;
        busy   <= 1'b1;
        prod_v <= 1'b0;
      end else if (busy) begin
        if (icnt != IdxW'(nbgai_pkg::MulChunks)) begin
          prod     <= ProdW'(a_r[icnt]) * ProdW'(b_r);
          prod_idx <= icnt;
          prod_v   <= 1'b1;
          icnt     <= icnt + 1'b1;
        end else begin
          prod_v <= 1'b0;
        end
        if (prod_v) begin
          acc <= acc + (nbgai_pkg::MulPW'(prod) << {prod_idx, 5'b0});
          if (prod_idx == IdxW'(nbgai_pkg::MulChunks - 1)) begin
            done <= 1'b1;
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/nbgai_back.sv -----
// Back sequencer: square root, pull division, accumulation and integration.
// Depends on nbgai_pkg, nbgai_mul and the assertion macro header.
`include "nbody_gravity_accumulate_integrate_core_defines.svh"

module nbgai_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        time_step,
  input  logic               q_empty,
  output logic               q_pop,
  input  nbgai_pkg::pair_t   q_data,
  output logic               empty,
  input  logic               pop,
  output nbgai_pkg::result_t result
);

  localparam int unsigned AccW      = nbgai_pkg::AccW;
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps  = 47;
  localparam int unsigned DenW      = 84;
  localparam logic [AccW-1:0] AccMax  = {1'b0, {(AccW - 1){1'b1}}};
  localparam logic [AccW-1:0] AccMin  = {1'b1, {(AccW - 1){1'b0}}};
  localparam logic [63:0]     PartCap = 64'h1000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_MUL, ST_DIVI, ST_DIV, ST_ACC, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MK_DEN, MK_NUM, MK_VDT, MK_ADT, MK_HADT
  } mul_kind_t;

  state_t           state;
  mul_kind_t        kind;
  logic [1:0]       axis;
  logic             mul_wait;
  logic [5:0]       cnt;
  nbgai_pkg::pair_t pr;
  logic [AccW-1:0]  acc_sum [3];

  // Square root datapath
  logic [65:0] srad;
  logic [35:0] srem;
  logic [32:0] root;
  logic [35:0] s_tr;
  logic [35:0] s_try;

  // Products and division lanes
  logic [DenW-1:0] den;
  logic [79:0]     num_p  [3];
  logic [63:0]     vdt_p  [3];
  logic [79:0]     adt_p  [3];
  logic [111:0]    hadt_p [3];
  logic [DenW:0]   drem   [3];
  logic [46:0]     dlow   [3];
  logic [46:0]     quo    [3];
  logic            dsat   [3];
  logic [DenW:0]   d_sh   [3];

  // Accumulate and integrate terms
  logic [31:0]      abs_v   [3];
  logic [AccW-1:0]  abs_a   [3];
  logic [AccW-1:0]  t_mag   [3];
  logic [AccW-1:0]  t_term  [3];
  logic [AccW-1:0]  t_base  [3];
  logic [AccW:0]    acc_wd  [3];
  logic [AccW-1:0]  acc_new [3];
  logic [63:0]      vdt_m   [3];
  logic [63:0]      adt_m   [3];
  logic [63:0]      hadt_m  [3];
  logic [63:0]      pos_sum [3];
  logic [63:0]      vel_sum [3];
  nbgai_pkg::result_t res_next;

  logic                        out_valid;
  logic                        mul_start;
  logic [nbgai_pkg::MulAW-1:0] mul_a;
  logic [nbgai_pkg::MulBW-1:0] mul_b;
  logic                        mul_busy;
  logic                        mul_done;
  logic [nbgai_pkg::MulPW-1:0] mul_p;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    logic [31:0] y;
    if (x[63] && !(&x[62:31])) begin
      y = 32'h8000_0000;
    end else if (!x[63] && (|x[62:31])) begin
      y = 32'h7FFF_FFFF;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign empty     = !out_valid;
  assign mul_start = (state == ST_MUL) && !mul_wait;

  nbgai_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Select multiplier operands for the current job
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (kind)
      MK_DEN: begin
        mul_a = nbgai_pkg::MulAW'(pr.r_sq);
        mul_b = root;
      end
      MK_NUM: begin
        mul_a = nbgai_pkg::MulAW'(pr.q_pull);
        mul_b = nbgai_pkg::MulBW'(pr.abs_d[axis]);
      end
      MK_VDT: begin
        mul_a = nbgai_pkg::MulAW'(abs_v[axis]);
        mul_b = nbgai_pkg::MulBW'(time_step);
      end
      MK_ADT: begin
        mul_a = nbgai_pkg::MulAW'(abs_a[axis]);
        mul_b = nbgai_pkg::MulBW'(time_step);
      end
      MK_HADT: begin
        mul_a = nbgai_pkg::MulAW'(adt_p[axis]);
        mul_b = nbgai_pkg::MulBW'(time_step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One square root digit per cycle
  assign s_tr  = {srem[33:0], srad[65:64]};
  assign s_try = {1'b0, root, 2'b01};

  // Division lanes, magnitudes and the accumulate step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_sh[k]  = {drem[k][DenW-1:0], dlow[k][46]};
      abs_v[k] = pr.tgt_vel[k][31] ? 32'(-pr.tgt_vel[k]) : pr.tgt_vel[k];
      abs_a[k] = acc_sum[k][AccW-1] ? AccW'(-acc_sum[k]) : acc_sum[k];

      t_mag[k] = '0;
      if (pr.r_sq != '0) begin
        t_mag[k] = dsat[k] ? AccMax : {1'b0, quo[k]};
      end
      t_term[k] = pr.neg_d[k] ? AccW'(-t_mag[k]) : t_mag[k];
      t_base[k] = pr.first_source ? '0 : acc_sum[k];
      acc_wd[k] = {t_base[k][AccW-1], t_base[k]} + {t_term[k][AccW-1], t_term[k]};
      if (acc_wd[k][AccW] != acc_wd[k][AccW-1]) begin
        acc_new[k] = acc_wd[k][AccW] ? AccMin : AccMax;
      end else begin
        acc_new[k] = acc_wd[k][AccW-1:0];
      end
    end
  end

  // Integrate one step: position and velocity per axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vdt_m[k]  = 64'(vdt_p[k][63:16]);
      adt_m[k]  = (adt_p[k][79:16] > PartCap) ? PartCap : adt_p[k][79:16];
      hadt_m[k] = (hadt_p[k][111:33] > 79'(PartCap)) ? PartCap : 64'(hadt_p[k][111:33]);
      pos_sum[k] = {{32{pr.tgt_pos[k][31]}}, pr.tgt_pos[k]}
                 + (pr.tgt_vel[k][31] ? -vdt_m[k] : vdt_m[k])
                 + (acc_sum[k][AccW-1] ? -hadt_m[k] : hadt_m[k]);
      vel_sum[k] = {{32{pr.tgt_vel[k][31]}}, pr.tgt_vel[k]}
                 + (acc_sum[k][AccW-1] ? -adt_m[k] : adt_m[k]);
      res_next.new_pos[k] = sat32(pos_sum[k]);
      res_next.new_vel[k] = sat32(vel_sum[k]);
    end
  end

  // Sequence one pair: root, products, division, accumulate, and on a last pair integrate
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      kind      <= MK_DEN;
      axis      <= '0;
      mul_wait  <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        acc_sum[k] <= '0;
      end
    end else begin
      // Drop the result once taken, unless a new one lands in its place
      if (pop && out_valid && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            pr    <= q_data;
            srad  <= {q_data.r_sq, 16'b0};
            srem  <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (s_tr >= s_try) begin
            srem <= s_tr - s_try;
            root <= {root[31:0], 1'b1};
          end else begin
            srem <= s_tr;
            root <= {root[31:0], 1'b0};
          end
          srad <= {srad[63:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == 6'(SqrtSteps - 1)) begin
            kind  <= MK_DEN;
            axis  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_start) begin
            mul_wait <= 1'b1;
          end else if (mul_done) begin
            mul_wait <= 1'b0;
            unique case (kind)
              MK_DEN: begin
                den  <= mul_p[DenW-1:0];
                kind <= MK_NUM;
                axis <= '0;
              end
              MK_NUM: begin
                num_p[axis] <= mul_p[79:0];
                if (axis == 2'd2) begin
                  state <= ST_DIVI;
                end else begin
                  axis <= axis + 1'b1;
                end
              end
              MK_VDT: begin
                vdt_p[axis] <= mul_p[63:0];
                if (axis == 2'd2) begin
                  kind <= MK_ADT;
                  axis <= '0;
                end else begin
                  axis <= axis + 1'b1;
                end
              end
              MK_ADT: begin
                adt_p[axis] <= mul_p[79:0];
                if (axis == 2'd2) begin
                  kind <= MK_HADT;
                  axis <= '0;
                end else begin
                  axis <= axis + 1'b1;
                end
              end
              MK_HADT: begin
                hadt_p[axis] <= mul_p[111:0];
                if (axis == 2'd2) begin
                  state <= ST_FIN;
                end else begin
                  axis <= axis + 1'b1;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DIVI: begin
          // Flag quotients that cannot fit, then seed each remainder
          for (int k = 0; k < 3; k++) begin
            dsat[k] <= (DenW'(num_p[k][79:31]) >= den);
            drem[k] <= (DenW + 1)'(num_p[k][79:31]);
            dlow[k] <= {num_p[k][30:0], 16'b0};
          end
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          for (int k = 0; k < 3; k++) begin
            if (d_sh[k] >= {1'b0, den}) begin
              drem[k] <= d_sh[k] - {1'b0, den};
              quo[k]  <= {quo[k][45:0], 1'b1};
            end else begin
              drem[k] <= d_sh[k];
              quo[k]  <= {quo[k][45:0], 1'b0};
            end
            dlow[k] <= {dlow[k][45:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'(DivSteps - 1)) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          for (int k = 0; k < 3; k++) begin
            acc_sum[k] <= acc_new[k];
          end
          if (pr.last_source) begin
            kind  <= MK_VDT;
            axis  <= '0;
            state <= ST_MUL;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_FIN: begin
          // Hold until the output register is free
          if (!out_valid || pop) begin
            result    <= res_next;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `NBGAI_ASSERT_NOW(a_done_in_mul, clk, rst, mul_done, (state == ST_MUL) && mul_wait, "multiplier finished outside a multiply step")
  `NBGAI_ASSERT_NEXT(a_fin_lands, clk, rst, (state == ST_FIN) && !out_valid, out_valid && (state == ST_IDLE), "result did not land in the output register")
  `NBGAI_ASSERT_NOW(a_div_complete, clk, rst, state == ST_ACC, cnt == 6'(DivSteps), "accumulate reached before the division finished")
  `NBGAI_ASSERT_NOW(a_mul_idle_on_start, clk, rst, mul_start, !mul_busy, "multiplier started while still busy")

endmodule

// ----- rtl/nbody_gravity_accumulate_integrate_core.sv -----
// Softened gravity direct sum with one-step integration, Q16.16 fixed point.
// Each request pairs a target with a source; the pull is added to a saturating
// 48-bit acceleration sum, and a request marked last yields the target's new
// position and velocity. A two-stage front pipeline takes one request per
// cycle while the queue has room, into a queue of QueueDepth pairs; the back
// sequencer works on one pair at a time (33-step square root, four products
// on the shared 32-bit chunk multiplier, a 47-step divider on three lanes)
// and runs nine more integration products on a last pair, so it sets the
// sustained rate. Configuration must be written only while the core is idle;
// the core itself does not enforce this. Depends on nbgai_pkg, nbgai_front,
// nbgai_queue, nbgai_mul and nbgai_back.
module nbody_gravity_accumulate_integrate_core #(
  parameter int unsigned QueueDepth = nbgai_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nbgai_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic signed [31:0]            tgt_pos_x,
  input  logic signed [31:0]            tgt_pos_y,
  input  logic signed [31:0]            tgt_pos_z,
  input  logic signed [31:0]            tgt_vel_x,
  input  logic signed [31:0]            tgt_vel_y,
  input  logic signed [31:0]            tgt_vel_z,
  input  logic signed [31:0]            src_pos_x,
  input  logic signed [31:0]            src_pos_y,
  input  logic signed [31:0]            src_pos_z,
  input  logic [31:0]                   src_mass,
  input  logic                          first_source,
  input  logic                          last_source,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            new_pos_x,
  output logic signed [31:0]            new_pos_y,
  output logic signed [31:0]            new_pos_z,
  output logic signed [31:0]            new_vel_x,
  output logic signed [31:0]            new_vel_y,
  output logic signed [31:0]            new_vel_z
);

  logic [31:0] gravity_const;
  logic [31:0] softening_sq;
  logic [31:0] time_step;

  nbgai_pkg::in_item_t in_item;
  nbgai_pkg::pair_t    q_wdata;
  nbgai_pkg::pair_t    q_rdata;
  nbgai_pkg::result_t  result;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_const <= nbgai_pkg::GravityReset;
      softening_sq  <= nbgai_pkg::SofteningReset;
      time_step     <= nbgai_pkg::TimeStepReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nbgai_pkg::CfgGravity:   gravity_const <= cfg_data;
        nbgai_pkg::CfgSoftening: softening_sq  <= cfg_data;
        nbgai_pkg::CfgTimeStep:  time_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gather the request fields
  always_comb begin
    in_item.tgt_pos[0]   = tgt_pos_x;
    in_item.tgt_pos[1]   = tgt_pos_y;
    in_item.tgt_pos[2]   = tgt_pos_z;
    in_item.tgt_vel[0]   = tgt_vel_x;
    in_item.tgt_vel[1]   = tgt_vel_y;
    in_item.tgt_vel[2]   = tgt_vel_z;
    in_item.src_pos[0]   = src_pos_x;
    in_item.src_pos[1]   = src_pos_y;
    in_item.src_pos[2]   = src_pos_z;
    in_item.src_mass     = src_mass;
    in_item.first_source = first_source;
    in_item.last_source  = last_source;
  end

  nbgai_front u_front (
    .clk           (clk),
    .rst           (rst),
    .gravity_const (gravity_const),
    .softening_sq  (softening_sq),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  nbgai_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  nbgai_back u_back (
    .clk       (clk),
    .rst       (rst),
    .time_step (time_step),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // Drive the result fields
  assign new_pos_x = result.new_pos[0];
  assign new_pos_y = result.new_pos[1];
  assign new_pos_z = result.new_pos[2];
  assign new_vel_x = result.new_vel[0];
  assign new_vel_y = result.new_vel[1];
  assign new_vel_z = result.new_vel[2];

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for the softened gravity accumulate and integrate core.
// Drives requests on push/full, pops results on pop/empty and checks them
// against an in-bench model; depends on nbgai_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;

  localparam logic [nbgai_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam longint AccMax = 64'sd140737488355327;
  localparam longint AccMin = -64'sd140737488355328;
  localparam longint PartCap = 64'sd1152921504606846976;
  localparam int unsigned SettleCycles = 800;

  typedef struct {
    bit [31:0] tp[3];
    bit [31:0] tv[3];
    bit [31:0] sp[3];
    bit [31:0] mass;
    bit        first;
    bit        last;
  } pair_req_t;

  typedef struct {
    bit [31:0] pos[3];
    bit [31:0] vel[3];
  } body_state_t;

  typedef struct {
    pair_req_t   req;
    bit          known;
    body_state_t state;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [nbgai_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic push = 0;
  logic full;
  logic signed [31:0] tgt_pos_x = 0, tgt_pos_y = 0, tgt_pos_z = 0;
  logic signed [31:0] tgt_vel_x = 0, tgt_vel_y = 0, tgt_vel_z = 0;
  logic signed [31:0] src_pos_x = 0, src_pos_y = 0, src_pos_z = 0;
  logic [31:0] src_mass = 0;
  logic first_source = 0;
  logic last_source = 0;
  logic empty;
  logic pop = 0;
  logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
  logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;

  nbody_gravity_accumulate_integrate_core dut (.*);

  always #4 clk = ~clk;

  // Model state: registers and running acceleration
  bit [31:0] grav_q, soft_sq, dt_q;
  longint accel[3];
  body_state_t pending_states[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit rx_hold = 0;
  event long_hold;

  function automatic bit [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit [63:0] isqrt(bit [127:0] n);
    bit [127:0] root;
    bit [127:0] cand;
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root[63:0];
  endfunction

  // Signed pull along one axis, saturated magnitude
  function automatic longint pull(longint d, bit [63:0] q, bit [63:0] r, bit [63:0] dlen);
    bit [127:0] num, den, quo;
    longint t;
    if (r == 0) return 0;
    num = (128'(q) * 128'(mag(d))) << 16;
    den = 128'(r) * 128'(dlen);
    quo = num / den;
    t = (quo > 128'(AccMax)) ? AccMax : longint'(quo[63:0]);
    return d < 0 ? -t : t;
  endfunction

  // floor(a*b*c / 2^sh), capped
  function automatic longint scaled(bit [63:0] a, bit [63:0] b, bit [63:0] c, int sh);
    bit [191:0] p;
    p = (192'(a) * 192'(b) * 192'(c)) >> sh;
    return (p > 192'(PartCap)) ? PartCap : longint'(p[63:0]);
  endfunction

  // Accumulate one pair; return 1 with the new body state on a last pair
  function automatic bit step_body(pair_req_t rq, output body_state_t st);
    longint d[3], p, v, vdt, adt, hadt2;
    bit [127:0] r;
    bit [63:0] m, dlen, q;
    st = '{default: '{default: 0}};
    r = soft_sq;
    for (int k = 0; k < 3; k++) begin
      d[k] = longint'($signed(rq.sp[k])) - longint'($signed(rq.tp[k]));
      m = mag(d[k]);
      r += (128'(m) * 128'(m)) >> 16;
    end
    dlen = isqrt(r << 16);
    q = (64'(grav_q) * 64'(rq.mass)) >> 16;
    if (rq.first) accel = '{0, 0, 0};
    for (int k = 0; k < 3; k++) begin
      accel[k] += pull(d[k], q, r[63:0], dlen);
      if (accel[k] > AccMax) accel[k] = AccMax;
      if (accel[k] < AccMin) accel[k] = AccMin;
    end
    if (!rq.last) return 0;
    for (int k = 0; k < 3; k++) begin
      p = $signed(rq.tp[k]);
      v = $signed(rq.tv[k]);
      vdt = scaled(mag(v), dt_q, 1, 16);
      adt = scaled(mag(accel[k]), dt_q, 1, 16);
      hadt2 = scaled(mag(accel[k]), dt_q, dt_q, 33);
      if (v < 0) vdt = -vdt;
      if (accel[k] < 0) begin
        adt = -adt;
        hadt2 = -hadt2;
      end
      st.pos[k] = 32'(sat32(p + vdt + hadt2));
      st.vel[k] = 32'(sat32(v + adt));
    end
    return 1;
  endfunction

  // Offer one request from a falling edge until accepted
  task automatic offer(pair_req_t rq, bit known, body_state_t typed);
    body_state_t st;
    while ($urandom_range(99) < snd_idle) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    tgt_pos_x <= rq.tp[0]; tgt_pos_y <= rq.tp[1]; tgt_pos_z <= rq.tp[2];
    tgt_vel_x <= rq.tv[0]; tgt_vel_y <= rq.tv[1]; tgt_vel_z <= rq.tv[2];
    src_pos_x <= rq.sp[0]; src_pos_y <= rq.sp[1]; src_pos_z <= rq.sp[2];
    src_mass <= rq.mass;
    first_source <= rq.first;
    last_source <= rq.last;
    forever begin
      @(posedge clk);
      if (!full) break;
      @(negedge clk);
    end
    if (step_body(rq, st)) pending_states.push_back(known ? typed : st);
    @(negedge clk);
  endtask

  // Drop push, wait out every pending result and the tail of the pipeline
  task automatic settle();
    push <= 0;
    while (pending_states.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic put_reg(logic [nbgai_pkg::CfgIdxW-1:0] idx, bit [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      nbgai_pkg::CfgGravity:   grav_q = val;
      nbgai_pkg::CfgSoftening: soft_sq = val;
      nbgai_pkg::CfgTimeStep:  dt_q = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_regs(bit [31:0] g, bit [31:0] s, bit [31:0] t);
    put_reg(nbgai_pkg::CfgGravity, g);
    put_reg(nbgai_pkg::CfgSoftening, s);
    put_reg(nbgai_pkg::CfgTimeStep, t);
    put_reg(CfgSpare, $urandom);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic walk_rows(dir_row_t rows[$]);
    foreach (rows[i]) offer(rows[i].req, rows[i].known, rows[i].state);
  endtask

  function automatic bit [31:0] rnd_word();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic bit [31:0] rnd_mass();
    case ($urandom_range(5))
      0: return 0;
      1: return 32'hffff_ffff;
      2, 3: return $urandom;
      default: return $urandom_range(32'h0010_0000);
    endcase
  endfunction

  // Source near, on, or far from the target
  function automatic bit [31:0] rnd_src(bit [31:0] t);
    case ($urandom_range(5))
      0: return t;
      1, 2: return t + ($urandom_range(32'h0004_0000) - 32'h0002_0000);
      default: return rnd_word();
    endcase
  endfunction

  // Mostly whole target sweeps, some broken flag sequences
  task automatic run_random(int n);
    pair_req_t rq;
    body_state_t none;
    int sent;
    int len;
    none = '{default: '{default: 0}};
    sent = 0;
    while (sent < n) begin
      for (int k = 0; k < 3; k++) begin
        rq.tp[k] = rnd_word();
        rq.tv[k] = rnd_word();
      end
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++) begin
          for (int k = 0; k < 3; k++) rq.sp[k] = rnd_src(rq.tp[k]);
          rq.mass = rnd_mass();
          rq.first = (j == 0);
          rq.last = (j == len - 1);
          offer(rq, 0, none);
        end
        sent += len;
      end else begin
        for (int k = 0; k < 3; k++) rq.sp[k] = rnd_src(rq.tp[k]);
        rq.mass = rnd_mass();
        rq.first = 1'($urandom_range(1));
        rq.last = 1'($urandom_range(1));
        offer(rq, 0, none);
        sent++;
      end
    end
  endtask

  // Receiver: random pops, held off during a long stall
  always @(negedge clk) begin
    pop <= !rx_hold && ($urandom_range(99) >= rcv_idle);
  end

  always @(long_hold) begin
    rx_hold = 1;
    repeat (3000) @(posedge clk);
    rx_hold = 0;
  end

  // Compare each popped result with the oldest pending state
  always @(posedge clk) begin
    body_state_t want;
    body_state_t got;
    if (!rst && pop && !empty) begin
      got.pos = '{new_pos_x, new_pos_y, new_pos_z};
      got.vel = '{new_vel_x, new_vel_y, new_vel_z};
      if (pending_states.size() == 0) begin
        $error("result popped with nothing pending");
        errors++;
      end else begin
        want = pending_states.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (got.pos[k] !== want.pos[k]) begin
            $error("new_pos[%0d]: expected %h, got %h", k, want.pos[k], got.pos[k]);
            errors++;
          end
          if (got.vel[k] !== want.vel[k]) begin
            $error("new_vel[%0d]: expected %h, got %h", k, want.vel[k], got.vel[k]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    dir_row_t rows_reset[$];
    dir_row_t rows_hot[$];
    bit [31:0] g_set[6], s_set[6], t_set[6];
    int snd_set[6], rcv_set[6];

    // Rows at reset settings: extremes, coincident pair, flag combinations
    rows_reset = '{
      '{'{'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, '{0, 0, 0}, '{0, 0, 0},
          0, 1, 1}, 1,
        '{'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000}, '{0, 0, 0}}},
      '{'{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, '{0, 0, 0},
          '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, 1, 1}, 1,
        '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, '{0, 0, 0}}},
      '{'{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
          '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
          '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 32'hffff_ffff, 1, 1}, 0,
        '{'{0, 0, 0}, '{0, 0, 0}}},
      '{'{'{0, 0, 0}, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
          '{32'h0000_8000, 32'hffff_8000, 32'h0001_0000}, 32'h0001_0000, 1, 1}, 0,
        '{'{0, 0, 0}, '{0, 0, 0}}},
      '{'{'{32'h0005_0000, 32'hfffb_0000, 0}, '{0, 0, 0},
          '{32'h0005_0000, 32'hfffb_0000, 0}, 32'hffff_ffff, 1, 1}, 1,
        '{'{32'h0005_0000, 32'hfffb_0000, 0}, '{0, 0, 0}}},
      '{'{'{32'h0001_0000, 0, 0}, '{32'h0000_1000, 0, 32'hffff_f000},
          '{32'h0003_0000, 32'h0001_0000, 0}, 32'h000a_0000, 1, 0}, 0,
        '{'{0, 0, 0}, '{0, 0, 0}}},
      '{'{'{32'h0001_0000, 0, 0}, '{32'h0000_1000, 0, 32'hffff_f000},
          '{32'hffff_0000, 0, 32'h0002_0000}, 32'h0020_0000, 0, 0}, 0,
        '{'{0, 0, 0}, '{0, 0, 0}}},
      '{'{'{32'h0001_0000, 0, 0}, '{32'h0000_1000, 0, 32'hffff_f000},
          '{32'h0001_0100, 32'h0000_0100, 32'hffff_ff00}, 32'h0001_0000, 0, 1}, 0,
        '{'{0, 0, 0}, '{0, 0, 0}}}
    };
    // Rows at maximum gravity and step, no softening: empty pull and saturation
    rows_hot = '{
      '{'{'{32'h0002_0000, 32'h0003_0000, 32'h0004_0000}, '{0, 0, 0},
          '{32'h0002_0000, 32'h0003_0000, 32'h0004_0000}, 32'hffff_ffff, 1, 1}, 1,
        '{'{32'h0002_0000, 32'h0003_0000, 32'h0004_0000}, '{0, 0, 0}}},
      '{'{'{0, 0, 0}, '{32'h1234_5678, 32'hedcb_a988, 0},
          '{1, 0, 32'hffff_ffff}, 32'hffff_ffff, 1, 0}, 0,
        '{'{0, 0, 0}, '{0, 0, 0}}},
      '{'{'{0, 0, 0}, '{32'h1234_5678, 32'hedcb_a988, 0},
          '{1, 0, 32'hffff_ffff}, 32'hffff_ffff, 0, 1}, 0,
        '{'{0, 0, 0}, '{0, 0, 0}}},
      '{'{'{32'h4000_0000, 32'hc000_0000, 0},
          '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
          '{32'hc000_0000, 32'h4000_0000, 32'h0000_0001}, 32'h0100_0000, 1, 1}, 0,
        '{'{0, 0, 0}, '{0, 0, 0}}}
    };

    grav_q = nbgai_pkg::GravityReset;
    soft_sq = nbgai_pkg::SofteningReset;
    dt_q = nbgai_pkg::TimeStepReset;
    accel = '{0, 0, 0};

    // Hold reset, release on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    walk_rows(rows_reset);
    settle();
    load_regs(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
    walk_rows(rows_hot);
    settle();

    // Random phases: settings sweep, idling pattern per phase
    g_set = '{32'h0001_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0010_0000,
              $urandom, 32'h0001_0000};
    s_set = '{32'd655, 32'd655, 32'h0000_0000, 32'hffff_ffff,
              $urandom_range(32'h0010_0000), 32'd655};
    t_set = '{32'd655, 32'h0001_0000, 32'd655, 32'hffff_ffff,
              $urandom_range(32'h0004_0000), 32'd655};
    snd_set = '{29, 29, 60, 60, 0, 0};
    rcv_set = '{60, 60, 29, 29, 0, 0};
    for (int ph = 0; ph < 6; ph++) begin
      load_regs(g_set[ph], s_set[ph], t_set[ph]);
      snd_idle = snd_set[ph];
      rcv_idle = rcv_set[ph];
      if (ph == 0) -> long_hold;
      run_random(185);
      settle();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
